// ===== design/text_console_writer_defines.svh =====
// Assertion shorthands for the text console writer.
// All checks are clocked on i_clk and held off while i_rst_n is low.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Condition must hold at every clock edge.
`define TCW_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tcw_pkg.sv =====
package tcw_pkg;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_READ,
        S_PUT,
        S_CLEAR,
        S_SCROLL,
        S_BLANK,
        S_HOLD
    } t_state;

    typedef enum logic [1:0] {
        REQ_PUT       = 2'd0,
        REQ_BACKSPACE = 2'd1,
        REQ_CLEAR     = 2'd2,
        REQ_READ      = 2'd3
    } t_req;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;
    localparam logic [7:0] RESET_ATTR   = 8'd15;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLANK_ATTR = 1'b1;

    // One screen cell: attribute in the high byte, character in the low byte.
    typedef struct packed {
        logic [7:0] attr;
        logic [7:0] chr;
    } t_cell;

endpackage

// ===== design/tcw_cell_ram.sv =====
module tcw_cell_ram
    import tcw_pkg::*;
#(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  t_cell             i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output t_cell             o_rdata
);

    t_cell r_mem [DEPTH];
    t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/text_console_writer.sv =====
// Steps: put character, backspace and out-of-range read finish in S_EXEC; an in-range
// read passes through S_READ and a line wrap through S_PUT; clear writes every cell in
// S_CLEAR; a scroll copies cells up one row in S_SCROLL, then blanks the last row in S_BLANK.
// Throughput: one item at a time; input stalls until the result is handed over.
// Reset (synchronous, active low) homes the cursor, sets both attributes to 15 and
// then sweeps the memory, stalling input, to blank every cell.
`include "text_console_writer_defines.svh"

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_req_type,
    input  logic [7:0]           i_char_code,
    input  logic [4:0]           i_read_row,
    input  logic [6:0]           i_read_col,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [4:0]           o_cursor_row,
    output logic [6:0]           o_cursor_col,
    output logic [10:0]          o_cursor_position,
    output logic [7:0]           o_cell_char,
    output logic [7:0]           o_cell_color,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    localparam int CELLS  = SCREEN_ROWS * SCREEN_COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);     // sweep counter and linear position
    localparam int ROW_W  = $clog2(SCREEN_ROWS);
    localparam int COL_W  = $clog2(SCREEN_COLS + 1); // column may sit at COLS (wrap pending)

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    t_state             r_state, n_state;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COL_W-1:0]   r_col, n_col;
    logic [CNT_W-1:0]   r_sweep, n_sweep;     // address walker for clear, scroll, blank
    logic               r_rd_pend, n_rd_pend; // scroll read issued last cycle
    logic               r_put_pend, n_put_pend; // character waits for the scroll to end
    logic [7:0]         r_text_attr;
    logic [7:0]         r_blank_attr;

    // latched request
    t_req               r_req;
    logic [7:0]         r_char;
    logic [4:0]         r_rrow;
    logic [6:0]         r_rcol;

    t_cell              r_cell_hold, n_cell_hold;

    // result register
    logic               r_out_valid;
    logic [4:0]         r_out_row;
    logic [6:0]         r_out_col;
    logic [10:0]        r_out_pos;
    logic [7:0]         r_out_char;
    logic [7:0]         r_out_attr;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic in_acc;
    logic out_free;
    logic fin;
    logic load;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign load       = fin && out_free;

    // ------------------------------------------------------------------
    // Cell memory
    // ------------------------------------------------------------------
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    t_cell             ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    t_cell             ram_rdata;

    tcw_cell_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Address arithmetic (multiplications by a constant column count)
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] cur_pos;   // linear position of the cursor
    logic [CNT_W-1:0] rd_pos;    // linear position of the requested read cell
    logic [CNT_W-1:0] res_pos;   // linear position reported with the result
    logic             row_last;
    logic             rd_in_range;
    t_cell            res_cell;

    assign cur_pos  = CNT_W'(r_row) * CNT_W'(SCREEN_COLS) + CNT_W'(r_col);
    assign rd_pos   = CNT_W'(r_rrow) * CNT_W'(SCREEN_COLS) + CNT_W'(r_rcol);
    assign res_pos  = CNT_W'(n_row) * CNT_W'(SCREEN_COLS) + CNT_W'(n_col);
    assign row_last = (r_row == ROW_W'(SCREEN_ROWS - 1));
    assign rd_in_range = (32'(r_rrow) < SCREEN_ROWS) && (32'(r_rcol) < SCREEN_COLS);

    // ------------------------------------------------------------------
    // Sequencer: next state, cursor and memory accesses
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_sweep     = r_sweep;
        n_rd_pend   = 1'b0;
        n_put_pend  = r_put_pend;
        n_cell_hold = r_cell_hold;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        fin         = 1'b0;
        res_cell    = r_cell_hold;

        unique case (r_state)
            S_INIT: begin
                // blank the screen with the reset attribute, whatever the registers say
                ram_we    = 1'b1;
                ram_waddr = r_sweep[ADDR_W-1:0];
                ram_wdata = '{attr: RESET_ATTR, chr: SPACE_CODE};
                n_sweep   = r_sweep + CNT_W'(1);
                if (r_sweep == CNT_W'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_cell_hold = '0;
                res_cell    = '0;
                unique case (r_req)
                    REQ_PUT: begin
                        if (r_char == NEWLINE_CODE) begin
                            n_col = '0;
                            if (!row_last) begin
                                n_row = r_row + ROW_W'(1);
                                fin   = 1'b1;
                            end else begin
                                n_put_pend = 1'b0;
                                n_sweep    = CNT_W'(SCREEN_COLS);
                                n_state    = S_SCROLL;
                            end
                        end else if (r_col >= COL_W'(SCREEN_COLS)) begin
                            // wrap first, then write the character on the new line
                            n_col = '0;
                            if (!row_last) begin
                                n_row   = r_row + ROW_W'(1);
                                n_state = S_PUT;
                            end else begin
                                n_put_pend = 1'b1;
                                n_sweep    = CNT_W'(SCREEN_COLS);
                                n_state    = S_SCROLL;
                            end
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = cur_pos[ADDR_W-1:0];
                            ram_wdata = '{attr: r_text_attr, chr: r_char};
                            n_col     = r_col + COL_W'(1);
                            fin       = 1'b1;
                        end
                    end

                    REQ_BACKSPACE: begin
                        fin = 1'b1;
                        if (r_row != '0 || r_col != '0) begin
                            // one cell back in linear order covers both the row step
                            // and the plain column step
                            ram_we    = 1'b1;
                            ram_waddr = ADDR_W'(cur_pos - CNT_W'(1));
                            ram_wdata = '{attr: r_text_attr, chr: SPACE_CODE};
                            if (r_col == '0) begin
                                n_row = r_row - ROW_W'(1);
                                n_col = COL_W'(SCREEN_COLS - 1);
                            end else begin
                                n_col = r_col - COL_W'(1);
                            end
                        end
                    end

                    REQ_CLEAR: begin
                        n_row   = '0;
                        n_col   = '0;
                        n_sweep = '0;
                        n_state = S_CLEAR;
                    end

                    REQ_READ: begin
                        if (rd_in_range) begin
                            ram_re    = 1'b1;
                            ram_raddr = rd_pos[ADDR_W-1:0];
                            n_state   = S_READ;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                endcase
            end

            S_READ: begin
                res_cell    = ram_rdata;
                n_cell_hold = ram_rdata;
                fin         = 1'b1;
            end

            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = cur_pos[ADDR_W-1:0];
                ram_wdata = '{attr: r_text_attr, chr: r_char};
                n_col     = r_col + COL_W'(1);
                fin       = 1'b1;
            end

            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_sweep[ADDR_W-1:0];
                ram_wdata = '{attr: r_blank_attr, chr: SPACE_CODE};
                n_sweep   = r_sweep + CNT_W'(1);
                if (r_sweep == CNT_W'(CELLS - 1)) begin
                    fin = 1'b1;
                end
            end

            S_SCROLL: begin
                // read cell i, write it back one row up in the next cycle
                if (r_rd_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_W'(r_sweep - CNT_W'(SCREEN_COLS + 1));
                    ram_wdata = ram_rdata;
                end
                if (r_sweep != CNT_W'(CELLS)) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_sweep[ADDR_W-1:0];
                    n_sweep   = r_sweep + CNT_W'(1);
                    n_rd_pend = 1'b1;
                end else begin
                    n_sweep = CNT_W'(CELLS - SCREEN_COLS);
                    n_state = S_BLANK;
                end
            end

            S_BLANK: begin
                ram_we    = 1'b1;
                ram_waddr = r_sweep[ADDR_W-1:0];
                ram_wdata = '{attr: r_blank_attr, chr: SPACE_CODE};
                n_sweep   = r_sweep + CNT_W'(1);
                if (r_sweep == CNT_W'(CELLS - 1)) begin
                    if (r_put_pend) begin
                        n_put_pend = 1'b0;
                        n_state    = S_PUT;
                    end else begin
                        fin = 1'b1;
                    end
                end
            end

            S_HOLD: begin
                fin = 1'b1;
            end

            default: begin
                n_state = S_INIT;
            end
        endcase

        // hand the result over, or park until the output register frees up
        if (fin) begin
            n_state = out_free ? S_IDLE : S_HOLD;
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_row        <= '0;
            r_col        <= '0;
            r_sweep      <= '0;
            r_rd_pend    <= 1'b0;
            r_put_pend   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_text_attr  <= RESET_ATTR;
            r_blank_attr <= RESET_ATTR;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_sweep     <= n_sweep;
            r_rd_pend   <= n_rd_pend;
            r_put_pend  <= n_put_pend;
            r_out_valid <= load || (r_out_valid && i_out_stall);
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_TEXT_ATTR:  r_text_attr  <= i_cfg_data;
                    REG_BLANK_ATTR: r_blank_attr <= i_cfg_data;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req  <= t_req'(i_req_type);
            r_char <= i_char_code;
            r_rrow <= i_read_row;
            r_rcol <= i_read_col;
        end
        r_cell_hold <= n_cell_hold;
        if (load) begin
            r_out_row  <= 5'(n_row);
            r_out_col  <= 7'(n_col);
            r_out_pos  <= 11'(res_pos);
            r_out_char <= res_cell.chr;
            r_out_attr <= res_cell.attr;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_cursor_row      = r_out_row;
    assign o_cursor_col      = r_out_col;
    assign o_cursor_position = r_out_pos;
    assign o_cell_char       = r_out_char;
    assign o_cell_color      = r_out_attr;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `TCW_ASSERT_NEXT(a_accept_exec, in_acc, r_state == S_EXEC, "accepted item not executed")
    `TCW_ASSERT_ALWAYS(a_col_range, r_col <= COL_W'(SCREEN_COLS), "cursor column past wrap")
    `TCW_ASSERT_ALWAYS(a_row_range, r_row <= ROW_W'(SCREEN_ROWS - 1), "cursor row off screen")
    `TCW_ASSERT_IMPLY(a_scroll_wr, r_rd_pend, r_sweep > CNT_W'(SCREEN_COLS), "scroll over top")

endmodule
